@@ hdl/ngs_pkg.sv @@
// Shared constants and word types for the next greater element finder.
package ngs_pkg;

  localparam int VALUE_WIDTH       = 32;
  localparam int STACK_DEPTH_DEF   = 64;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          end_of_array;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] element;
    logic signed [VALUE_WIDTH-1:0] successor;
    logic                          last_of_run;
    logic                          overflow;
  } out_word_t;

endpackage

@@ hdl/ngs_stack_mem.sv @@
// Single-port-write, single-port-read stack memory with a registered read.
module ngs_stack_mem
  import ngs_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(STACK_DEPTH)-1:0]     wr_addr,
  input  logic signed [VALUE_WIDTH-1:0]      wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(STACK_DEPTH)-1:0]     rd_addr,
  output logic signed [VALUE_WIDTH-1:0]      rd_data
);

  logic signed [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/next_greater_element_stack.sv @@
// Next greater element finder: a strictly decreasing stack held in a memory.
//
// Each accepted word is compared with the values still waiting for a greater
// successor; every smaller one is popped and reported as a pair with the new
// value, an equal top is merged silently, and the new value is then pushed
// (the word marked end_of_array is not pushed and empties the stack instead).
// The stack lives in a synchronous memory organised as a ring, with a copy of
// its top kept in a register, so a push onto a full stack overwrites the
// oldest entry in place and sets the sticky overflow flag. An item passes
// through accept and compare, and each pop that leaves a value on the stack
// adds a fill step, as the new top must come back through the memory's
// registered read. A pop that empties the stack needs none. Stalls on the
// result channel add to this. No clearing pass is needed after reset.
module next_greater_element_stack
  import ngs_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]             base_r, base_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          hold_valid_r, hold_valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] top_r, top_nxt;
  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                          last_r, last_nxt;
  logic signed [VALUE_WIDTH-1:0] hold_r, hold_nxt;
  out_word_t                     out_r, out_nxt;

  logic                          mem_wr_en;
  logic [ADDR_W-1:0]             mem_wr_addr;
  logic                          mem_rd_en;
  logic [ADDR_W-1:0]             mem_rd_addr;
  logic signed [VALUE_WIDTH-1:0] mem_rd_data;

  logic              out_free;
  logic              top_lt;
  logic              top_eq;
  logic              full;
  logic [SUM_W-1:0]  wr_sum;
  logic [SUM_W-1:0]  rd_sum;
  logic [ADDR_W-1:0] base_inc;

  ngs_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (val_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign top_lt   = (cnt_r != '0) && (top_r < val_r);
  assign top_eq   = (cnt_r != '0) && (top_r == val_r);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));

  // Ring addressing: entry i of the stack lives at (base + i) mod depth.
  // Both sums stay below twice the depth whenever they are used, so one subtract wraps them.
  assign wr_sum      = SUM_W'(base_r) + SUM_W'(cnt_r);
  assign rd_sum      = SUM_W'(base_r) + SUM_W'(cnt_r) - SUM_W'(2);
  assign mem_wr_addr = (wr_sum >= SUM_W'(STACK_DEPTH)) ?
                       ADDR_W'(wr_sum - SUM_W'(STACK_DEPTH)) : ADDR_W'(wr_sum);
  assign mem_rd_addr = (rd_sum >= SUM_W'(STACK_DEPTH)) ?
                       ADDR_W'(rd_sum - SUM_W'(STACK_DEPTH)) : ADDR_W'(rd_sum);
  assign base_inc    = (base_r == ADDR_W'(STACK_DEPTH - 1)) ? '0 : base_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    ovf_nxt        = ovf_r;
    hold_valid_nxt = hold_valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    top_nxt        = top_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    hold_nxt       = hold_r;
    out_nxt        = out_r;
    mem_wr_en      = 1'b0;
    mem_rd_en      = 1'b0;
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt   = in_data.value;
          last_nxt  = in_data.end_of_array;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // A popped value waits in the hold register until we know whether
        // it was the last pair of this word.
        if (!hold_valid_r || out_free) begin
          if (hold_valid_r) begin
            out_valid_nxt            = 1'b1;
            out_nxt.element          = hold_r;
            out_nxt.successor        = val_r;
            out_nxt.last_of_run      = !top_lt;
            out_nxt.overflow         = ovf_r;
          end
          if (top_lt) begin
            hold_nxt       = top_r;
            hold_valid_nxt = 1'b1;
            cnt_nxt        = cnt_r - 1'b1;
            if (cnt_r >= CNT_W'(2)) begin
              mem_rd_en = 1'b1;
              state_nxt = S_FILL;
            end
          end else begin
            hold_valid_nxt = 1'b0;
            state_nxt      = S_IDLE;
            if (last_r) begin
              cnt_nxt = '0;
            end else if (!top_eq) begin
              // An equal top would be popped and pushed again unchanged.
              mem_wr_en = 1'b1;
              top_nxt   = val_r;
              if (full) begin
                base_nxt = base_inc;
                ovf_nxt  = 1'b1;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
        end
      end
      S_FILL: begin
        top_nxt   = mem_rd_data;
        state_nxt = S_CMP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      base_r       <= '0;
      ovf_r        <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      base_r       <= base_nxt;
      ovf_r        <= ovf_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds the depth");

  a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= ADDR_W'(STACK_DEPTH - 1))
    else $error("ring base out of range");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_valid_r)
    else $error("popped value left behind at the end of a word");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_fill_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> $past(mem_rd_en))
    else $error("top refresh without a memory read");
`endif

endmodule
